### src/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

  localparam int MaxPatternDefault = 16;
  localparam int MaxReplDefault    = 16;
  localparam int QueueDepth        = 2;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 64;
  localparam int LenWidth      = 5;

  typedef logic [CfgIndexWidth-1:0] cfg_index_t;

  localparam cfg_index_t REG_PATTERN_LEN  = 3'd0;
  localparam cfg_index_t REG_PATTERN_LOW  = 3'd1;
  localparam cfg_index_t REG_PATTERN_HIGH = 3'd2;
  localparam cfg_index_t REG_REPL_LEN     = 3'd3;
  localparam cfg_index_t REG_REPL_LOW     = 3'd4;
  localparam cfg_index_t REG_REPL_HIGH    = 3'd5;

  // what the back end plays out for one request
  typedef enum logic [1:0] {
    JOB_WINDOW,
    JOB_REPL,
    JOB_EMPTY
  } job_kind_t;

  typedef struct packed {
    job_kind_t kind;
    logic      last;
  } job_ctrl_t;

  function automatic int max_count(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

### src/sfr_queue.sv
`default_nettype none

module sfr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sfr_pkg::QueueDepth
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [NW-1:0]    count;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### src/sfr_front.sv
`default_nettype none

module sfr_front #(
  parameter int MAX_PATTERN     = sfr_pkg::MaxPatternDefault,
  parameter int MAX_REPLACEMENT = sfr_pkg::MaxReplDefault
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [7:0]                             in_byte,
  input  wire logic                                   in_last,
  input  wire logic [sfr_pkg::LenWidth-1:0]           pattern_len,
  input  wire logic [MAX_PATTERN-1:0][7:0]            pattern,
  input  wire logic [sfr_pkg::LenWidth-1:0]           repl_len,
  input  wire logic                                   q_full,
  output logic                                        q_push,
  output sfr_pkg::job_ctrl_t                          job_ctrl,
  output logic [$clog2(sfr_pkg::max_count(MAX_PATTERN, MAX_REPLACEMENT)+1)-1:0] job_count,
  output logic [MAX_PATTERN-1:0][7:0]                 job_data
);

  localparam int MaxCount = sfr_pkg::max_count(MAX_PATTERN, MAX_REPLACEMENT);
  localparam int CW       = $clog2(MaxCount + 1);
  localparam int FW       = $clog2(MAX_PATTERN + 1);

  logic [MAX_PATTERN-1:0][7:0] window;
  logic [MAX_PATTERN-1:0][7:0] window_next;
  logic [MAX_PATTERN-1:0][7:0] win_in;
  logic [MAX_PATTERN-1:0][7:0] win_shift;
  logic [FW-1:0]               fill;
  logic [FW-1:0]               fill_next;
  logic [FW-1:0]               new_fill;
  logic [FW-1:0]               plen;
  logic [CW-1:0]               rlen;
  logic                        accept;
  logic                        stale;
  logic                        full_win;
  logic                        match;
  logic                        need_push;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && need_push;
  assign job_data = win_in;

  assign plen = (pattern_len > sfr_pkg::LenWidth'(MAX_PATTERN)) ?
                FW'(MAX_PATTERN) : FW'(pattern_len);
  assign rlen = (repl_len > sfr_pkg::LenWidth'(MAX_REPLACEMENT)) ?
                CW'(MAX_REPLACEMENT) : CW'(repl_len);

  assign new_fill = fill + FW'(1);
  assign stale    = (fill >= plen);
  assign full_win = !stale && (new_fill == plen);

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_in[i] = (FW'(i) == fill) ? in_byte : window[i];
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((FW'(i) < plen) && (win_in[i] != pattern[i])) begin
        match = 1'b0;
      end
    end
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      win_shift[i] = win_in[i+1];
    end
    win_shift[MAX_PATTERN-1] = win_in[MAX_PATTERN-1];
  end

  always_comb begin
    window_next   = full_win ? win_shift : win_in;
    job_ctrl.kind = sfr_pkg::JOB_WINDOW;
    job_ctrl.last = in_last;
    job_count     = CW'(1);
    need_push     = 1'b0;
    fill_next     = '0;
    if (stale) begin
      // pass-through, or window left over from a longer pattern
      job_count = CW'(fill) + CW'(1);
      need_push = 1'b1;
    end else if (full_win && match) begin
      job_ctrl.kind = sfr_pkg::JOB_REPL;
      job_count     = rlen;
      need_push     = (rlen != '0);
      if ((rlen == '0) && in_last) begin
        job_ctrl.kind = sfr_pkg::JOB_EMPTY;
        job_count     = CW'(1);
        need_push     = 1'b1;
      end
    end else if (full_win) begin
      job_count = in_last ? CW'(plen) : CW'(1);
      need_push = 1'b1;
      fill_next = in_last ? '0 : plen - FW'(1);
    end else begin
      job_count = CW'(new_fill);
      need_push = in_last;
      fill_next = in_last ? '0 : new_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

endmodule

`default_nettype wire

### src/sfr_back.sv
`default_nettype none

module sfr_back #(
  parameter int MAX_PATTERN     = sfr_pkg::MaxPatternDefault,
  parameter int MAX_REPLACEMENT = sfr_pkg::MaxReplDefault
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   q_empty,
  output logic                                        q_pop,
  input  wire sfr_pkg::job_ctrl_t                     job_ctrl,
  input  wire logic [$clog2(sfr_pkg::max_count(MAX_PATTERN, MAX_REPLACEMENT)+1)-1:0] job_count,
  input  wire logic [MAX_PATTERN-1:0][7:0]            job_data,
  input  wire logic [MAX_REPLACEMENT-1:0][7:0]        repl,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [7:0]                                  out_byte,
  output logic                                        out_has,
  output logic                                        out_last
);

  localparam int MaxCount = sfr_pkg::max_count(MAX_PATTERN, MAX_REPLACEMENT);
  localparam int CW       = $clog2(MaxCount + 1);
  localparam int XW       = (MaxCount > 1) ? $clog2(MaxCount) : 1;

  logic [XW-1:0] idx;
  logic          load;
  logic          at_end;
  logic [7:0]    win_byte;
  logic [7:0]    rep_byte;
  logic [7:0]    sel_byte;

  assign load   = !out_valid || out_ready;
  assign at_end = (CW'(idx) == job_count - CW'(1));
  assign q_pop  = load && !q_empty && at_end;

  always_comb begin
    win_byte = '0;
    rep_byte = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (XW'(i) == idx) begin
        win_byte = job_data[i];
      end
    end
    for (int i = 0; i < MAX_REPLACEMENT; i++) begin
      if (XW'(i) == idx) begin
        rep_byte = repl[i];
      end
    end
    unique case (job_ctrl.kind)
      sfr_pkg::JOB_WINDOW: sel_byte = win_byte;
      sfr_pkg::JOB_REPL:   sel_byte = rep_byte;
      sfr_pkg::JOB_EMPTY:  sel_byte = '0;
      default:             sel_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        idx <= at_end ? '0 : idx + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_byte <= sel_byte;
      out_has  <= (job_ctrl.kind != sfr_pkg::JOB_EMPTY);
      out_last <= job_ctrl.last && at_end;
    end
  end

endmodule

`default_nettype wire

### src/stream_find_replace.sv
// stream_find_replace: replaces every leftmost, non-overlapping occurrence
// of a pattern (0..16 bytes) in a byte stream by a replacement (0..16 bytes).
// Input: s_tvalid/s_tready/s_tdata (byte) /s_tlast (end of stream).
// Output: m_tvalid/m_tready/m_tdata (byte) /m_tuser (has_byte)/m_tlast.
// An m_tuser of 0 is the empty end marker, sent when a last input leaves
// nothing to emit. Config: cfg_valid/cfg_ready/cfg_index/cfg_data, always
// ready; write only while the stream is idle.
// The front end updates the pending window and issues at most one request
// per input, 0 to 16 bytes long, into a two-entry queue; the back end plays
// requests out at one byte per cycle while m_tready is high, through a
// registered output stage. Throughput: one input per cycle while each input
// yields at most one byte and m_tready is high; an input yielding k bytes
// holds the output until all k are sent, and the input stalls once the queue
// is full. An input's bytes pass through a queue entry, then the output
// register. Reset clears the window fill, the queue pointers and count,
// out_valid, the byte index and the config registers. When m_tready is low
// the output holds and the queue fills, then s_tready drops.
`default_nettype none

module stream_find_replace #(
  parameter int MAX_PATTERN     = sfr_pkg::MaxPatternDefault,
  parameter int MAX_REPLACEMENT = sfr_pkg::MaxReplDefault
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,   // in_byte
  input  wire logic                              s_tlast,   // in_last
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [7:0]                             m_tdata,   // out_byte
  output logic                                   m_tuser,   // has_byte
  output logic                                   m_tlast,   // out_last
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sfr_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [sfr_pkg::CfgDataWidth-1:0]  cfg_data
);

  localparam int MaxCount = sfr_pkg::max_count(MAX_PATTERN, MAX_REPLACEMENT);
  localparam int CW       = $clog2(MaxCount + 1);
  localparam int EW       = $bits(sfr_pkg::job_ctrl_t) + CW + MAX_PATTERN * 8;

  logic [sfr_pkg::LenWidth-1:0]     pattern_len;
  logic [sfr_pkg::CfgDataWidth-1:0] pattern_low;
  logic [sfr_pkg::CfgDataWidth-1:0] pattern_high;
  logic [sfr_pkg::LenWidth-1:0]     repl_len;
  logic [sfr_pkg::CfgDataWidth-1:0] repl_low;
  logic [sfr_pkg::CfgDataWidth-1:0] repl_high;

  logic [2*sfr_pkg::CfgDataWidth-1:0] pattern_all;
  logic [2*sfr_pkg::CfgDataWidth-1:0] repl_all;
  logic [MAX_PATTERN-1:0][7:0]        pattern;
  logic [MAX_REPLACEMENT-1:0][7:0]    repl;

  logic                        q_full;
  logic                        q_empty;
  logic                        q_push;
  logic                        q_pop;
  logic [EW-1:0]               q_wr;
  logic [EW-1:0]               q_rd;
  sfr_pkg::job_ctrl_t          wr_ctrl;
  logic [CW-1:0]               wr_count;
  logic [MAX_PATTERN-1:0][7:0] wr_data;
  sfr_pkg::job_ctrl_t          rd_ctrl;
  logic [CW-1:0]               rd_count;
  logic [MAX_PATTERN-1:0][7:0] rd_data;

  assign cfg_ready   = 1'b1;
  assign pattern_all = {pattern_high, pattern_low};
  assign repl_all    = {repl_high, repl_low};
  assign pattern     = pattern_all[MAX_PATTERN*8-1:0];
  assign repl        = repl_all[MAX_REPLACEMENT*8-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len  <= '0;
      pattern_low  <= '0;
      pattern_high <= '0;
      repl_len     <= '0;
      repl_low     <= '0;
      repl_high    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sfr_pkg::REG_PATTERN_LEN:  pattern_len  <= cfg_data[sfr_pkg::LenWidth-1:0];
        sfr_pkg::REG_PATTERN_LOW:  pattern_low  <= cfg_data;
        sfr_pkg::REG_PATTERN_HIGH: pattern_high <= cfg_data;
        sfr_pkg::REG_REPL_LEN:     repl_len     <= cfg_data[sfr_pkg::LenWidth-1:0];
        sfr_pkg::REG_REPL_LOW:     repl_low     <= cfg_data;
        sfr_pkg::REG_REPL_HIGH:    repl_high    <= cfg_data;
        default: ;
      endcase
    end
  end

  sfr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_byte     (s_tdata),
    .in_last     (s_tlast),
    .pattern_len (pattern_len),
    .pattern     (pattern),
    .repl_len    (repl_len),
    .q_full      (q_full),
    .q_push      (q_push),
    .job_ctrl    (wr_ctrl),
    .job_count   (wr_count),
    .job_data    (wr_data)
  );

  assign q_wr = {wr_ctrl, wr_count, wr_data};
  assign {rd_ctrl, rd_count, rd_data} = q_rd;

  sfr_queue #(
    .WIDTH (EW),
    .DEPTH (sfr_pkg::QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  sfr_back #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .job_ctrl  (rd_ctrl),
    .job_count (rd_count),
    .job_data  (rd_data),
    .repl      (repl),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_has   (m_tuser),
    .out_last  (m_tlast)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full && !q_pop))
    else $error("request pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("request popped from empty queue");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata == 8'd0)))
    else $error("empty marker not a zero last result");
`endif

endmodule

`default_nettype wire

### dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxPat      = sfr_pkg::MaxPatternDefault;
  localparam int MaxRepl     = sfr_pkg::MaxReplDefault;
  localparam int DrainCycles = 20;
  localparam int SettleLimit = 50000;
  localparam int MaxReports  = 10;

  localparam sfr_pkg::cfg_index_t REG_SPARE_6 = 3'd6;
  localparam sfr_pkg::cfg_index_t REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } out_item_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata   = 8'h00;   // in_byte
  logic                s_tlast   = 1'b0;    // in_last
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [7:0]          m_tdata;             // out_byte
  logic                m_tuser;             // has_byte
  logic                m_tlast;             // out_last
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  sfr_pkg::cfg_index_t cfg_index = '0;
  logic [63:0]         cfg_data  = '0;

  // shadow of the block's registers and pending window
  logic [4:0]   pat_len_q  = '0;
  logic [4:0]   repl_len_q = '0;
  logic [127:0] pat_bytes  = '0;
  logic [127:0] repl_bytes = '0;
  logic [7:0]   pend [MaxPat];
  int           pend_fill  = 0;

  out_item_t    due_bytes [$];
  logic [7:0]   alphabet [3];

  int fail_count   = 0;
  int bytes_in     = 0;
  int writes_done  = 0;
  int results_out  = 0;
  int empty_marks  = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  stream_find_replace dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #10_000_000;
    $display("stream_find_replace: mismatch");
    $finish;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxReports) begin
      $display("[%0t] ERROR: %s", $time, msg);
    end
  endfunction

  function automatic void find_replace_step(input logic [7:0] b, input logic lst);
    out_item_t made [$];
    out_item_t tail;
    int        plen;
    int        rlen;
    logic      hit;
    plen = (pat_len_q > MaxPat) ? MaxPat : int'(pat_len_q);
    rlen = (repl_len_q > MaxRepl) ? MaxRepl : int'(repl_len_q);
    if (pend_fill >= plen) begin
      // pass-through, or window left stale by a shorter pattern
      for (int i = 0; i < pend_fill; i++) made.push_back('{pend[i], 1'b1, 1'b0});
      pend_fill = 0;
      made.push_back('{b, 1'b1, 1'b0});
    end else begin
      pend[pend_fill] = b;
      pend_fill++;
      if (pend_fill == plen) begin
        hit = 1'b1;
        for (int i = 0; i < plen; i++) begin
          if (pend[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          for (int i = 0; i < rlen; i++) made.push_back('{repl_bytes[8*i +: 8], 1'b1, 1'b0});
          pend_fill = 0;
        end else begin
          made.push_back('{pend[0], 1'b1, 1'b0});
          for (int i = 1; i < pend_fill; i++) pend[i-1] = pend[i];
          pend_fill--;
        end
      end
      if (lst) begin
        for (int i = 0; i < pend_fill; i++) made.push_back('{pend[i], 1'b1, 1'b0});
        pend_fill = 0;
      end
    end
    if (lst) begin
      if (made.size() == 0) made.push_back('{8'h00, 1'b0, 1'b0});
      tail = made.pop_back();
      tail.last = 1'b1;
      made.push_back(tail);
    end
    foreach (made[i]) due_bytes.push_back(made[i]);
  endfunction

  always @(posedge clk) begin : out_monitor
    out_item_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_out++;
        if (!m_tuser) empty_marks++;
        if (due_bytes.size() == 0) begin
          note_failure($sformatf("unexpected result byte %02h has_byte %0b last %0b",
                                 m_tdata, m_tuser, m_tlast));
        end else begin
          want = due_bytes.pop_front();
          if (m_tdata !== want.data || m_tuser !== want.has_byte || m_tlast !== want.last) begin
            note_failure($sformatf(
              "got byte %02h has_byte %0b last %0b, expected byte %02h has_byte %0b last %0b",
              m_tdata, m_tuser, m_tlast, want.data, want.has_byte, want.last));
          end
        end
      end
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic write_cfg(input sfr_pkg::cfg_index_t idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    writes_done++;
    case (idx)
      sfr_pkg::REG_PATTERN_LEN:  pat_len_q = value[4:0];
      sfr_pkg::REG_PATTERN_LOW:  pat_bytes[63:0] = value;
      sfr_pkg::REG_PATTERN_HIGH: pat_bytes[127:64] = value;
      sfr_pkg::REG_REPL_LEN:     repl_len_q = value[4:0];
      sfr_pkg::REG_REPL_LOW:     repl_bytes[63:0] = value;
      sfr_pkg::REG_REPL_HIGH:    repl_bytes[127:64] = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic push_stream_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    bytes_in++;
    find_replace_step(b, lst);
  endtask

  // sender quiet until every predicted result is out, then let the pipe empty
  task automatic drain_output();
    int waited;
    s_tvalid <= 1'b0;
    waited = 0;
    while (due_bytes.size() != 0 && waited < SettleLimit) begin
      @(posedge clk);
      waited++;
    end
    if (due_bytes.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", due_bytes.size()));
      due_bytes.delete();
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic test_passthrough();
    write_cfg(REG_SPARE_6, {$urandom, $urandom});
    write_cfg(REG_SPARE_7, {$urandom, $urandom});
    write_cfg(sfr_pkg::REG_PATTERN_LEN, 64'd0);
    push_stream_byte(8'h00, 1'b0);
    push_stream_byte(8'hff, 1'b1);
    drain_output();
  endtask

  task automatic test_find_replace();
    logic [63:0] pat;
    pat = {$urandom, $urandom};
    pat[23:0] = 24'h626161;
    write_cfg(sfr_pkg::REG_PATTERN_LEN, 64'd3);
    write_cfg(sfr_pkg::REG_PATTERN_LOW, pat);
    write_cfg(sfr_pkg::REG_PATTERN_HIGH, {$urandom, $urandom});
    write_cfg(sfr_pkg::REG_REPL_LEN, 64'd5);
    write_cfg(sfr_pkg::REG_REPL_LOW, {$urandom, $urandom});
    write_cfg(sfr_pkg::REG_REPL_HIGH, {$urandom, $urandom});
    // overlapping candidate, then a match, then a partial window flushed by last
    push_stream_byte(8'h61, 1'b0);
    push_stream_byte(8'h61, 1'b0);
    push_stream_byte(8'h61, 1'b0);
    push_stream_byte(8'h62, 1'b0);
    push_stream_byte(8'h61, 1'b1);
    drain_output();
  endtask

  task automatic test_delete_to_empty();
    write_cfg(sfr_pkg::REG_PATTERN_LEN, 64'd2);
    write_cfg(sfr_pkg::REG_PATTERN_LOW, 64'h0000_0000_0000_2010);
    write_cfg(sfr_pkg::REG_REPL_LEN, 64'd0);
    push_stream_byte(8'h10, 1'b0);
    push_stream_byte(8'h20, 1'b1);
    drain_output();
  endtask

  task automatic test_longest_lengths();
    // 31 exceeds both maxima and is clamped to 16
    write_cfg(sfr_pkg::REG_PATTERN_LEN, 64'd31);
    write_cfg(sfr_pkg::REG_PATTERN_LOW, {$urandom, $urandom});
    write_cfg(sfr_pkg::REG_PATTERN_HIGH, {$urandom, $urandom});
    write_cfg(sfr_pkg::REG_REPL_LEN, 64'd31);
    write_cfg(sfr_pkg::REG_REPL_LOW, 64'hffff_ffff_ffff_ffff);
    write_cfg(sfr_pkg::REG_REPL_HIGH, {$urandom, $urandom});
    for (int i = 0; i < MaxPat; i++) push_stream_byte(pat_bytes[8*i +: 8], i == MaxPat - 1);
    drain_output();
  endtask

  task automatic test_pattern_shortened();
    write_cfg(sfr_pkg::REG_PATTERN_LEN, 64'd4);
    write_cfg(sfr_pkg::REG_PATTERN_LOW, {$urandom, $urandom});
    for (int i = 0; i < 3; i++) push_stream_byte(pat_bytes[8*i +: 8], 1'b0);
    drain_output();
    write_cfg(sfr_pkg::REG_PATTERN_LEN, 64'd2);
    push_stream_byte(8'h33, 1'b0);
    drain_output();
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r <= 6) return $urandom_range(4, 1);
    if (r == 7) return 16;
    if (r == 8) return $urandom_range(31, 17);
    return $urandom_range(15, 5);
  endfunction

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count,
                                     input bit pause_mid);
    logic [7:0]   piece [$];
    logic [127:0] pat;
    int           plen;
    int           sent;
    int           kind;
    int           n;
    bit           end_here;
    bit           paused;
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    foreach (alphabet[i]) alphabet[i] = 8'($urandom);
    for (int i = 0; i < 16; i++) begin
      pat[8*i +: 8] = $urandom_range(3) != 0 ? alphabet[$urandom_range(2)] : 8'($urandom);
    end
    write_cfg(sfr_pkg::REG_PATTERN_LOW, pat[63:0]);
    write_cfg(sfr_pkg::REG_PATTERN_HIGH, pat[127:64]);
    write_cfg(sfr_pkg::REG_PATTERN_LEN, 64'(pick_len()));
    write_cfg(sfr_pkg::REG_REPL_LOW, {$urandom, $urandom});
    write_cfg(sfr_pkg::REG_REPL_HIGH, {$urandom, $urandom});
    write_cfg(sfr_pkg::REG_REPL_LEN, 64'(pick_len()));
    plen = (pat_len_q > MaxPat) ? MaxPat : int'(pat_len_q);
    sent = 0;
    paused = 1'b0;
    while (sent < count) begin
      piece.delete();
      end_here = 1'b0;
      kind = $urandom_range(9);
      if (kind <= 4) begin
        if (plen == 0) piece.push_back(8'($urandom));
        for (int i = 0; i < plen; i++) piece.push_back(pat_bytes[8*i +: 8]);
        end_here = ($urandom_range(4) == 0);
      end else if (kind <= 6 && plen > 1) begin
        n = $urandom_range(plen - 1, 1);
        for (int i = 0; i < n; i++) piece.push_back(pat_bytes[8*i +: 8]);
        piece.push_back(alphabet[$urandom_range(2)]);
      end else if (kind <= 8) begin
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++) begin
          piece.push_back($urandom_range(1) ? alphabet[$urandom_range(2)] : 8'($urandom));
        end
      end else begin
        piece.push_back(alphabet[$urandom_range(2)]);
        end_here = 1'b1;
      end
      foreach (piece[i]) push_stream_byte(piece[i], end_here && i == piece.size() - 1);
      sent += piece.size();
      if (pause_mid && !paused && sent >= count / 2) begin
        drain_output();
        paused = 1'b1;
      end
    end
    // leave the stream open at random so the next setup meets a stale window
    if ($urandom_range(1)) push_stream_byte(alphabet[0], 1'b1);
    drain_output();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_passthrough();
    test_find_replace();
    test_delete_to_empty();
    test_longest_lengths();
    test_pattern_shortened();
    test_random_traffic(0, 0, 34, 1'b0);
    test_random_traffic(60, 0, 34, 1'b1);
    test_random_traffic(0, 60, 34, 1'b0);
    test_random_traffic(35, 35, 34, 1'b0);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    drain_output();
    $display("%0d bytes in, %0d results out (%0d empty end markers), %0d register writes",
             bytes_in, results_out, empty_marks, writes_done);
    $display("covered pass-through, replace, delete, clamped lengths, stale window, %0d errors",
             fail_count);
    if (fail_count == 0) begin
      $display("stream_find_replace: match");
    end else begin
      $display("stream_find_replace: mismatch");
    end
    $finish;
  end

endmodule

### stream_find_replace.f
src/sfr_pkg.sv
src/sfr_queue.sv
src/sfr_front.sv
src/sfr_back.sv
src/stream_find_replace.sv
dv/testbench.sv
